[hdl/lumi_pkg.sv]
// Shared constants, types and fixed-point helpers for the LU matrix inverse.
// No dependencies.
`timescale 1ns / 1ps
package lumi_pkg;
    localparam int MAX_ORDER = 8;
    localparam int FRAC_BITS = 16;
    localparam int CELLS     = MAX_ORDER * MAX_ORDER;
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ORD_W     = IDX_W + 1;

    typedef logic signed [31:0] fx_t;

    // Clamp a 34-bit signed sum to the 32-bit range.
    function automatic fx_t sat_sum(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        begin
            hi = 34'sd2147483647;
            lo = -34'sd2147483648;
            if (v > hi)
                sat_sum = 32'sh7fffffff;
            else if (v < lo)
                sat_sum = 32'sh80000000;
            else
                sat_sum = v[31:0];
        end
    endfunction

    // Apply a sign to an unsigned magnitude and clamp.
    function automatic fx_t from_mag(input logic neg, input logic [63:0] mag);
        begin
            if (neg)
                from_mag = (mag >= 64'd2147483648) ? 32'sh80000000 : -$signed(mag[31:0]);
            else
                from_mag = (mag > 64'd2147483647) ? 32'sh7fffffff : $signed(mag[31:0]);
        end
    endfunction

    function automatic logic [31:0] mag_of(input fx_t a);
        begin
            mag_of = a[31] ? (~a + 32'd1) : a;
        end
    endfunction
endpackage

[hdl/lumi_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module lumi_ram #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int WIDTH  = 32
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

[hdl/lumi_mul.sv]
// Fixed-point multiplier, rounded and saturated, two register stages.
// Depends on lumi_pkg.
`timescale 1ns / 1ps
module lumi_mul
    import lumi_pkg::*;
(
    input  logic clk,
    input  fx_t  a,
    input  fx_t  b,
    output fx_t  p
);
    logic [63:0] prod_reg;
    logic        neg_reg;
    logic [63:0] rnd;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, mag_of(a)} * {32'd0, mag_of(b)};
        neg_reg  <= a[31] ^ b[31];
    end

    assign rnd = (prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

    always_ff @(posedge clk)
    begin
        p <= from_mag(neg_reg, rnd);
    end
endmodule

[hdl/lumi_div.sv]
// Restoring divider, one quotient bit a cycle, rounded and saturated.
// Depends on lumi_pkg.
`timescale 1ns / 1ps
module lumi_div
    import lumi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  fx_t  a,
    input  fx_t  b,
    output logic done,
    output fx_t  q
);
    localparam int NW = 32 + FRAC_BITS + 1;

    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [NW:0]   rem_reg;
    logic [31:0]   den_reg;
    logic          neg_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic [NW:0]   trial;
    logic [NW:0]   den_ext;

    assign trial   = {rem_reg[NW-1:0], num_reg[NW-1]};
    assign den_ext = {{(NW-31){1'b0}}, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                // numerator doubled plus den gives rounding ties away from zero
                num_reg  <= ({{(NW-32){1'b0}}, mag_of(a)} << (FRAC_BITS + 1))
                            + {{(NW-32){1'b0}}, mag_of(b)};
                den_reg  <= mag_of(b);
                neg_reg  <= a[31] ^ b[31];
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= 6'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= num_reg << 1;
                if (trial >= den_ext)
                begin
                    rem_reg <= trial - den_ext;
                    quo_reg <= {quo_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // quotient of (2N+D)/(2D) floored equals round(N/D) ties away
    always_comb
    begin
        q = from_mag(neg_reg, {{(64-NW){1'b0}}, quo_reg >> 1});
    end
endmodule

[hdl/lu_matrix_inverse.sv]
// Top level of the LU matrix inverse: load, factor, solve and drain sequencer
// around the matrix and inverse memories. Depends on lumi_pkg, lumi_ram,
// lumi_mul and lumi_div.
//
// Usage: the input channel (in_valid/in_stall, matrix_element) takes one
// matrix entry per item in row-major order. After n*n entries (n from
// matrix_order, 0 read as 1, above 8 read as 8) the block stalls input,
// factors the matrix by Doolittle LU without pivoting and solves one unit
// column at a time. Each factor update and each substitution term is a
// memory read, the two-stage multiplier and a saturated add; each division
// runs on the bit-serial divider. Then it emits n*n results on the output
// channel (out_valid/out_stall) in row-major order, with out_valid low
// between results, last_result on the final one, singular on all of them if
// a zero pivot was seen (values are then zero). A stalled result holds its
// value. Reset sets the order to 8 and empties the load. Writing
// matrix_order (cfg_we) during the load restarts it; it is ignored otherwise.
`timescale 1ns / 1ps
module lu_matrix_inverse
    import lumi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] matrix_element,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] inverse_value,
    output logic        last_result,
    output logic        singular
);
    typedef enum logic [4:0] {
        S_LOAD, S_F_PIV, S_F_PIVW, S_F_LRD, S_F_LRDW, S_F_DIVW,
        S_F_URD, S_F_URDW, S_F_MULW, S_F_UWR,
        S_S_INIT, S_S_RD, S_S_RDW, S_S_MULW, S_S_ACC, S_S_FIN,
        S_B_DIAG, S_B_DIAGW, S_B_DIVW, S_B_STORE,
        S_O_RD, S_O_RDW, S_O_HOLD
    } state_t;

    state_t state_reg;
    logic [3:0]       order_reg;
    logic [ORD_W-1:0] n;
    logic [ADDR_W:0]  load_reg;
    logic [IDX_W:0]   k_reg, i_reg, j_reg, c_reg;
    logic             bwd_reg;
    logic             pz_reg;
    fx_t              piv_reg, f_reg, acc_reg, tmp_reg;
    fx_t              fwd_reg [MAX_ORDER];
    fx_t              sol_reg [MAX_ORDER];
    logic [2:0]       wait_reg;
    logic [ADDR_W:0]  out_cnt_reg;
    logic [ADDR_W:0]  total;

    // matrix memory
    logic             m_we;
    logic [ADDR_W-1:0] m_waddr, m_raddr;
    fx_t              m_wdata, m_rdata;
    // inverse memory
    logic             v_we;
    logic [ADDR_W-1:0] v_waddr, v_raddr;
    fx_t              v_wdata, v_rdata;

    fx_t  mul_a, mul_b, mul_p;
    logic div_start, div_done;
    fx_t  div_a, div_b, div_q;

    lumi_ram #(.DEPTH(CELLS), .AW(ADDR_W), .WIDTH(32)) u_mat (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata));
    lumi_ram #(.DEPTH(CELLS), .AW(ADDR_W), .WIDTH(32)) u_inv (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata));
    lumi_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
    lumi_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .a(div_a),
        .b(div_b), .done(div_done), .q(div_q));

    always_comb
    begin
        if (order_reg == 4'd0)
            n = ORD_W'(1);
        else if (order_reg > 4'(MAX_ORDER))
            n = ORD_W'(MAX_ORDER);
        else
            n = order_reg[ORD_W-1:0];
    end
    assign total = (ADDR_W+1)'(n * n);

    function automatic logic [ADDR_W-1:0] adr(input logic [IDX_W:0] r,
                                              input logic [IDX_W:0] c);
        begin
            adr = {r[IDX_W-1:0], c[IDX_W-1:0]};
        end
    endfunction

    assign in_stall = (state_reg != S_LOAD);

    // element index in load: row = load/n, col = load%n, walked by counters
    logic [IDX_W:0] lr_reg, lc_reg;

    always_comb
    begin
        m_we = 1'b0; m_waddr = adr(lr_reg, lc_reg); m_wdata = matrix_element;
        m_raddr = '0;
        v_we = 1'b0; v_waddr = adr(i_reg, c_reg); v_wdata = '0; v_raddr = '0;
        mul_a = f_reg; mul_b = m_rdata;
        div_start = 1'b0; div_a = m_rdata; div_b = piv_reg;
        unique case (state_reg)
            S_LOAD:   m_we = in_valid;
            S_F_PIV:  m_raddr = adr(k_reg, k_reg);
            S_F_LRD:  m_raddr = adr(i_reg, k_reg);
            S_F_LRDW: div_start = 1'b1;
            S_F_DIVW:
            begin
                m_we = div_done; m_waddr = adr(i_reg, k_reg); m_wdata = div_q;
            end
            S_F_URD:  m_raddr = adr(k_reg, j_reg);
            S_F_URDW: m_raddr = adr(i_reg, j_reg);
            S_F_UWR:
            begin
                m_we = 1'b1; m_waddr = adr(i_reg, j_reg);
                m_wdata = sat_sum({{2{tmp_reg[31]}}, tmp_reg} - {{2{mul_p[31]}}, mul_p});
            end
            S_S_RD:   m_raddr = adr(i_reg, j_reg);
            S_S_RDW:  mul_a = bwd_reg ? sol_reg[j_reg[IDX_W-1:0]] : fwd_reg[j_reg[IDX_W-1:0]];
            S_B_DIAG: m_raddr = adr(i_reg, i_reg);
            S_B_DIAGW:
            begin
                div_start = 1'b1; div_a = acc_reg; div_b = m_rdata;
            end
            S_B_STORE:
            begin
                v_we = 1'b1; v_wdata = sol_reg[i_reg[IDX_W-1:0]];
            end
            S_O_RD:   v_raddr = adr(i_reg, j_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            order_reg <= 4'(MAX_ORDER);
            load_reg  <= '0;
            lr_reg    <= '0;
            lc_reg    <= '0;
            out_valid <= 1'b0;
            pz_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg_we)
                    begin
                        order_reg <= cfg_wdata;
                        load_reg <= '0; lr_reg <= '0; lc_reg <= '0;
                    end
                    else if (in_valid)
                    begin
                        if (lc_reg == IDX_W'(0) + n - 1'b1)
                        begin
                            lc_reg <= '0; lr_reg <= lr_reg + 1'b1;
                        end
                        else
                            lc_reg <= lc_reg + 1'b1;
                        load_reg <= load_reg + 1'b1;
                        if (load_reg + 1'b1 == total)
                        begin
                            load_reg <= '0; lr_reg <= '0; lc_reg <= '0;
                            pz_reg <= 1'b0; k_reg <= '0;
                            state_reg <= S_F_PIV;
                        end
                    end
                end
                S_F_PIV:  state_reg <= S_F_PIVW;
                S_F_PIVW:
                begin
                    piv_reg <= m_rdata;
                    if (m_rdata == 32'sd0)
                    begin
                        pz_reg <= 1'b1; state_reg <= S_S_INIT;
                    end
                    else if ({1'b0, k_reg} + 2'd1 >= {1'b0, n})
                        state_reg <= S_S_INIT;
                    else
                    begin
                        i_reg <= k_reg + 1'b1; state_reg <= S_F_LRD;
                    end
                end
                S_F_LRD:  state_reg <= S_F_LRDW;
                S_F_LRDW: state_reg <= S_F_DIVW;
                S_F_DIVW:
                    if (div_done)
                    begin
                        f_reg <= div_q; j_reg <= k_reg + 1'b1; state_reg <= S_F_URD;
                    end
                S_F_URD:  state_reg <= S_F_URDW;
                S_F_URDW:
                begin
                    wait_reg <= 3'd0; state_reg <= S_F_MULW;
                end
                S_F_MULW:
                begin
                    if (wait_reg == 3'd0) tmp_reg <= m_rdata;
                    wait_reg <= wait_reg + 3'd1;
                    if (wait_reg == 3'd0) state_reg <= S_F_UWR;
                end
                S_F_UWR:
                begin
                    if (j_reg + 1'b1 < n)
                    begin
                        j_reg <= j_reg + 1'b1; state_reg <= S_F_URD;
                    end
                    else if (i_reg + 1'b1 < n)
                    begin
                        i_reg <= i_reg + 1'b1; state_reg <= S_F_LRD;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1; state_reg <= S_F_PIV;
                    end
                end
                // substitution: forward then backward per column
                S_S_INIT:
                begin
                    c_reg <= '0; i_reg <= '0; bwd_reg <= 1'b0;
                    acc_reg <= (FRAC_BITS < 31) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
                    j_reg <= '0;
                    if (pz_reg)
                    begin
                        i_reg <= '0; j_reg <= '0; out_cnt_reg <= '0; state_reg <= S_O_RD;
                    end
                    else
                        state_reg <= S_S_FIN;
                end
                S_S_RD:   state_reg <= S_S_RDW;
                S_S_RDW:
                begin
                    wait_reg <= 3'd0; state_reg <= S_S_MULW;
                end
                S_S_MULW:
                begin
                    wait_reg <= wait_reg + 3'd1;
                    if (wait_reg == 3'd0) state_reg <= S_S_ACC;
                end
                S_S_ACC:
                begin
                    if (bwd_reg)
                        acc_reg <= sat_sum({{2{acc_reg[31]}}, acc_reg} + {{2{mul_p[31]}}, mul_p});
                    else
                        acc_reg <= sat_sum({{2{acc_reg[31]}}, acc_reg} - {{2{mul_p[31]}}, mul_p});
                    j_reg <= j_reg + 1'b1;
                    state_reg <= S_S_FIN;
                end
                S_S_FIN:
                begin
                    // more terms in this row?
                    if (!bwd_reg && j_reg < i_reg)
                        state_reg <= S_S_RD;
                    else if (bwd_reg && j_reg < n)
                        state_reg <= S_S_RD;
                    else if (!bwd_reg)
                    begin
                        fwd_reg[i_reg[IDX_W-1:0]] <= acc_reg;
                        if (i_reg + 1'b1 < n)
                        begin
                            i_reg <= i_reg + 1'b1; j_reg <= '0;
                            acc_reg <= (i_reg + 1'b1 == c_reg) ?
                                       (32'sd1 <<< FRAC_BITS) : 32'sd0;
                        end
                        else
                        begin
                            bwd_reg <= 1'b1; j_reg <= i_reg + 1'b1;
                            acc_reg <= '0;
                        end
                    end
                    else
                    begin
                        acc_reg <= sat_sum({{2{fwd_reg[i_reg[IDX_W-1:0]][31]}},
                                            fwd_reg[i_reg[IDX_W-1:0]]}
                                           - {{2{acc_reg[31]}}, acc_reg});
                        state_reg <= S_B_DIAG;
                    end
                end
                S_B_DIAG:  state_reg <= S_B_DIAGW;
                S_B_DIAGW: state_reg <= S_B_DIVW;
                S_B_DIVW:
                    if (div_done)
                    begin
                        sol_reg[i_reg[IDX_W-1:0]] <= div_q; state_reg <= S_B_STORE;
                    end
                S_B_STORE:
                begin
                    if (i_reg != '0)
                    begin
                        i_reg <= i_reg - 1'b1; j_reg <= i_reg; acc_reg <= '0;
                        state_reg <= S_S_FIN;
                    end
                    else if (c_reg + 1'b1 < n)
                    begin
                        c_reg <= c_reg + 1'b1; bwd_reg <= 1'b0;
                        i_reg <= '0; j_reg <= '0;
                        acc_reg <= (c_reg + 1'b1 == '0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
                        state_reg <= S_S_FIN;
                    end
                    else
                    begin
                        i_reg <= '0; j_reg <= '0; out_cnt_reg <= '0; state_reg <= S_O_RD;
                    end
                end
                S_O_RD:   state_reg <= S_O_RDW;
                S_O_RDW:
                begin
                    inverse_value <= pz_reg ? 32'sd0 : v_rdata;
                    singular      <= pz_reg;
                    last_result   <= (out_cnt_reg + 1'b1 == total);
                    out_valid     <= 1'b1;
                    state_reg     <= S_O_HOLD;
                end
                S_O_HOLD:
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        out_cnt_reg <= out_cnt_reg + 1'b1;
                        if (out_cnt_reg + 1'b1 == total)
                            state_reg <= S_LOAD;
                        else
                        begin
                            if (j_reg + 1'b1 < n)
                                j_reg <= j_reg + 1'b1;
                            else
                            begin
                                j_reg <= '0; i_reg <= i_reg + 1'b1;
                            end
                            state_reg <= S_O_RD;
                        end
                    end
                default: state_reg <= S_LOAD;
            endcase
            // forward row 0 starts with i==0==c; the backward start sets i=n-1
            if (state_reg == S_S_FIN && !bwd_reg && !(j_reg < i_reg)
                && !(i_reg + 1'b1 < n))
                i_reg <= IDX_W'(0) + n - 1'b1;
        end
    end

    // the matrix is never written while results are being shown
    a_no_write_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !m_we) else $error("matrix write during output");
    // a held result keeps its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(inverse_value))
        else $error("result changed while stalled");
    // no input is taken while results drain
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input open during output");
endmodule
